### hw/rtl/hrtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtu_pkg
// Types, operation codes and saturation helpers for the HI/LO transfer unit.
// ----------------------------------------------------------------------------
package hrtu_pkg;

    localparam int DwordWidth = 64;
    localparam int KindWidth  = 5;

    typedef logic [DwordWidth-1:0] dword_t;
    typedef logic [KindWidth-1:0]  kind_t;

    localparam kind_t KIND_MFHI      = 5'd0;
    localparam kind_t KIND_MFLO      = 5'd1;
    localparam kind_t KIND_MOVN      = 5'd2;
    localparam kind_t KIND_MOVZ      = 5'd3;
    localparam kind_t KIND_MTHI      = 5'd4;
    localparam kind_t KIND_MTLO      = 5'd5;
    localparam kind_t KIND_MFHI1     = 5'd6;
    localparam kind_t KIND_MFLO1     = 5'd7;
    localparam kind_t KIND_MTHI1     = 5'd8;
    localparam kind_t KIND_MTLO1     = 5'd9;
    localparam kind_t KIND_PMFHI     = 5'd10;
    localparam kind_t KIND_PMFLO     = 5'd11;
    localparam kind_t KIND_PMTHI     = 5'd12;
    localparam kind_t KIND_PMTLO     = 5'd13;
    localparam kind_t KIND_PMTHL_LW  = 5'd14;
    localparam kind_t KIND_PMFHL_LW  = 5'd15;
    localparam kind_t KIND_PMFHL_UW  = 5'd16;
    localparam kind_t KIND_PMFHL_SLW = 5'd17;
    localparam kind_t KIND_PMFHL_LH  = 5'd18;
    localparam kind_t KIND_PMFHL_SH  = 5'd19;

    typedef struct packed {
        kind_t  kind;
        dword_t src_low;
        dword_t src_high;
        dword_t cond_value;
    } in_beat_t;

    typedef struct packed {
        dword_t dest_low;
        dword_t dest_high;
        logic   write_low;
        logic   write_high;
    } out_beat_t;

    typedef struct packed {
        dword_t [1:0] hi;
        dword_t [1:0] lo;
    } hilo_t;

    typedef struct packed {
        logic  en;
        hilo_t value;
    } hilo_upd_t;

    function automatic dword_t sat64to32(input dword_t v);
        logic [32:0] top;
        top = v[63:31];
        if ((&top) || (~|top)) begin
            return v;
        end else if (v[63]) begin
            return 64'hFFFF_FFFF_8000_0000;
        end else begin
            return 64'h0000_0000_7FFF_FFFF;
        end
    endfunction

    function automatic logic [15:0] sat32to16(input logic [31:0] w);
        logic [16:0] top;
        top = w[31:15];
        if ((&top) || (~|top)) begin
            return w[15:0];
        end else if (w[31]) begin
            return 16'h8000;
        end else begin
            return 16'h7FFF;
        end
    endfunction

endpackage

### hw/rtl/hrtu_hilo_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtu_hilo_store
// HI and LO registers, two dwords each, cleared on reset.
// ----------------------------------------------------------------------------
module hrtu_hilo_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  hrtu_pkg::hilo_upd_t upd,
    output hrtu_pkg::hilo_t     hilo
);

    hrtu_pkg::hilo_t hilo_reg;
    hrtu_pkg::hilo_t hilo_next;

    always_comb begin
        hilo_next = upd.en ? upd.value : hilo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hilo_reg <= '0;
        end else begin
            hilo_reg <= hilo_next;
        end
    end

    assign hilo = hilo_reg;

endmodule

### hw/rtl/hrtu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtu_exec
// Decode one transfer beat: form the destination value and the new HI/LO.
// ----------------------------------------------------------------------------
module hrtu_exec (
    input  hrtu_pkg::in_beat_t  op,
    input  hrtu_pkg::hilo_t     hilo,
    output hrtu_pkg::out_beat_t res,
    output hrtu_pkg::hilo_t     hilo_new
);

    always_comb begin
        res      = '0;
        hilo_new = hilo;
        case (op.kind)
            hrtu_pkg::KIND_MFHI: begin
                res.dest_low  = hilo.hi[0];
                res.write_low = 1'b1;
            end
            hrtu_pkg::KIND_MFLO: begin
                res.dest_low  = hilo.lo[0];
                res.write_low = 1'b1;
            end
            hrtu_pkg::KIND_MOVN: begin
                if (op.cond_value != '0) begin
                    res.dest_low  = op.src_low;
                    res.write_low = 1'b1;
                end
            end
            hrtu_pkg::KIND_MOVZ: begin
                if (op.cond_value == '0) begin
                    res.dest_low  = op.src_low;
                    res.write_low = 1'b1;
                end
            end
            hrtu_pkg::KIND_MTHI:  hilo_new.hi[0] = op.src_low;
            hrtu_pkg::KIND_MTLO:  hilo_new.lo[0] = op.src_low;
            hrtu_pkg::KIND_MFHI1: begin
                res.dest_low  = hilo.hi[1];
                res.write_low = 1'b1;
            end
            hrtu_pkg::KIND_MFLO1: begin
                res.dest_low  = hilo.lo[1];
                res.write_low = 1'b1;
            end
            hrtu_pkg::KIND_MTHI1: hilo_new.hi[1] = op.src_low;
            hrtu_pkg::KIND_MTLO1: hilo_new.lo[1] = op.src_low;
            hrtu_pkg::KIND_PMFHI: begin
                res = '{hilo.hi[0], hilo.hi[1], 1'b1, 1'b1};
            end
            hrtu_pkg::KIND_PMFLO: begin
                res = '{hilo.lo[0], hilo.lo[1], 1'b1, 1'b1};
            end
            hrtu_pkg::KIND_PMTHI: begin
                hilo_new.hi[0] = op.src_low;
                hilo_new.hi[1] = op.src_high;
            end
            hrtu_pkg::KIND_PMTLO: begin
                hilo_new.lo[0] = op.src_low;
                hilo_new.lo[1] = op.src_high;
            end
            hrtu_pkg::KIND_PMTHL_LW: begin
                hilo_new.lo[0][31:0] = op.src_low[31:0];
                hilo_new.hi[0][31:0] = op.src_low[63:32];
                hilo_new.lo[1][31:0] = op.src_high[31:0];
                hilo_new.hi[1][31:0] = op.src_high[63:32];
            end
            hrtu_pkg::KIND_PMFHL_LW: begin
                res.dest_low   = {hilo.hi[0][31:0], hilo.lo[0][31:0]};
                res.dest_high  = {hilo.hi[1][31:0], hilo.lo[1][31:0]};
                res.write_low  = 1'b1;
                res.write_high = 1'b1;
            end
            hrtu_pkg::KIND_PMFHL_UW: begin
                res.dest_low   = {hilo.hi[0][63:32], hilo.lo[0][63:32]};
                res.dest_high  = {hilo.hi[1][63:32], hilo.lo[1][63:32]};
                res.write_low  = 1'b1;
                res.write_high = 1'b1;
            end
            hrtu_pkg::KIND_PMFHL_SLW: begin
                res.dest_low   = hrtu_pkg::sat64to32({hilo.hi[0][31:0], hilo.lo[0][31:0]});
                res.dest_high  = hrtu_pkg::sat64to32({hilo.hi[1][31:0], hilo.lo[1][31:0]});
                res.write_low  = 1'b1;
                res.write_high = 1'b1;
            end
            hrtu_pkg::KIND_PMFHL_LH: begin
                res.dest_low   = {hilo.hi[0][47:32], hilo.hi[0][15:0],
                                  hilo.lo[0][47:32], hilo.lo[0][15:0]};
                res.dest_high  = {hilo.hi[1][47:32], hilo.hi[1][15:0],
                                  hilo.lo[1][47:32], hilo.lo[1][15:0]};
                res.write_low  = 1'b1;
                res.write_high = 1'b1;
            end
            hrtu_pkg::KIND_PMFHL_SH: begin
                res.dest_low   = {hrtu_pkg::sat32to16(hilo.hi[0][63:32]),
                                  hrtu_pkg::sat32to16(hilo.hi[0][31:0]),
                                  hrtu_pkg::sat32to16(hilo.lo[0][63:32]),
                                  hrtu_pkg::sat32to16(hilo.lo[0][31:0])};
                res.dest_high  = {hrtu_pkg::sat32to16(hilo.hi[1][63:32]),
                                  hrtu_pkg::sat32to16(hilo.hi[1][31:0]),
                                  hrtu_pkg::sat32to16(hilo.lo[1][63:32]),
                                  hrtu_pkg::sat32to16(hilo.lo[1][31:0])};
                res.write_low  = 1'b1;
                res.write_high = 1'b1;
            end
            default: begin
                res      = '0;
                hilo_new = hilo;
            end
        endcase
    end

endmodule

### hw/rtl/hilo_register_transfer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilo_register_transfer_unit
// HI/LO register transfer unit: one transfer instruction per beat.
//
//   Channel   Prefix  Payload               Direction
//   input     s_      hrtu_pkg::in_beat_t   in
//   result    m_      hrtu_pkg::out_beat_t  out
//
// A beat is registered on entry, decoded against HI/LO from the input register and
// lands in the result register; one beat can be taken every cycle while the result
// is not stalled. HI/LO change as a beat moves into the result register.
// Reset clears HI, LO and both valid flags. A stalled result holds both
// stages; s_ready follows m_ready when both stages are full.
// ----------------------------------------------------------------------------
module hilo_register_transfer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrtu_pkg::in_beat_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output hrtu_pkg::out_beat_t m_payload
);

    logic                in_valid_reg;
    logic                in_valid_next;
    hrtu_pkg::in_beat_t  in_reg;
    hrtu_pkg::in_beat_t  in_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    hrtu_pkg::out_beat_t out_reg;
    hrtu_pkg::out_beat_t out_next;

    logic                advance;
    hrtu_pkg::hilo_t     hilo;
    hrtu_pkg::hilo_t     hilo_new;
    hrtu_pkg::out_beat_t res;
    hrtu_pkg::hilo_upd_t upd;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    hrtu_exec u_exec (
        .op       (in_reg),
        .hilo     (hilo),
        .res      (res),
        .hilo_new (hilo_new)
    );

    assign upd.en    = advance;
    assign upd.value = hilo_new;

    hrtu_hilo_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .hilo    (hilo)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_next       = s_payload;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule
